// ===== rtl/rds_pkg.sv =====
// Shared constants and types for the ray DDA setup block.
package rds_pkg;

    localparam int TILE_SIZE = 64;
    localparam int TILE_LOG2 = $clog2(TILE_SIZE);
    // one cell spans TILE_SIZE pixels in Q.8
    localparam int SPAN_LOG2 = TILE_LOG2 + 8;
    localparam int NUM_W     = SPAN_LOG2 + 1;

    // pi * 2^31, turns an eighth-turn index into Q30 radians
    localparam logic [32:0] ANG_K   = 33'd6746518852;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

    // Horner steps: x / D computed as (x * R) >> K, exact for x < 2^30
    localparam int HORNER_STEPS = 4;
    localparam int SIN_K [HORNER_STEPS] = '{37, 36, 35, 33};
    localparam int COS_K [HORNER_STEPS] = '{36, 35, 34, 31};
    localparam logic [30:0] SIN_R [HORNER_STEPS] = '{
        31'(((64'd1 << 37) + 64'd71) / 64'd72),
        31'(((64'd1 << 36) + 64'd41) / 64'd42),
        31'(((64'd1 << 35) + 64'd19) / 64'd20),
        31'(((64'd1 << 33) + 64'd5) / 64'd6)
    };
    localparam logic [30:0] COS_R [HORNER_STEPS] = '{
        31'(((64'd1 << 36) + 64'd55) / 64'd56),
        31'(((64'd1 << 35) + 64'd29) / 64'd30),
        31'(((64'd1 << 34) + 64'd11) / 64'd12),
        31'(((64'd1 << 31) + 64'd1) / 64'd2)
    };

    // configuration register index, byte address is index * 4
    typedef enum logic [1:0] {
        REG_BASE_ANG,
        REG_ANG_INCR,
        REG_PLAYER_X,
        REG_PLAYER_Y
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        ang;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } t_trig_res;

    typedef struct packed {
        t_trig_res   trig;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
    } t_recip_res;

    typedef struct packed {
        logic [15:0]        ray_ang;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [9:0]         cell_x;
        logic [9:0]         cell_y;
        logic signed [1:0]  step_x;
        logic signed [1:0]  step_y;
        logic [31:0]        delta_dist_x;
        logic [31:0]        delta_dist_y;
        logic [31:0]        side_dist_x;
        logic [31:0]        side_dist_y;
    } t_ray_out;

    // pipeline control shared by all stages
    typedef struct packed {
        logic en;
    } t_pipe_ctl;

endpackage

// ===== rtl/rds_trig.sv =====
// Ray angle and Q1.14 cosine/sine pipeline (Taylor series, Horner form).
module rds_trig import rds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pipe_ctl   i_ctl,
    input  logic        i_valid,
    input  logic [9:0]  i_col_idx,
    input  logic [15:0] i_base_ang,
    input  logic [15:0] i_ang_incr,
    output logic        o_valid,
    output t_trig_res   o_res
);

    typedef struct packed {
        logic [15:0] ang;
        logic [1:0]  quad;
        logic        swap;
        logic [29:0] th;
        logic [29:0] t2;
    } t_side;

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} t_quad;

    logic        w_en;
    logic [25:0] w_idx_prod;
    assign w_en       = i_ctl.en;
    assign w_idx_prod = i_col_idx * i_ang_incr;

    // stage 0: angle
    logic        r_v0;
    logic [15:0] r_ang0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (w_en) r_v0 <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_ang0 <= i_base_ang + w_idx_prod[15:0];
    end

    // stage 1: fold into an eighth turn
    logic [13:0] w_r;
    logic        w_swap;
    logic [13:0] w_m;
    assign w_r    = r_ang0[13:0];
    assign w_swap = w_r > 14'd8192;
    assign w_m    = w_swap ? 14'(15'd16384 - {1'b0, w_r}) : w_r;

    logic        r_v1;
    t_side       r_side1;
    logic [13:0] r_m1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= r_v0;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side1 <= '{ang: r_ang0, quad: r_ang0[15:14], swap: w_swap, th: '0, t2: '0};
            r_m1    <= w_m;
        end
    end

    // stage 2: m * pi * 2^31
    logic        r_v2;
    t_side       r_side2;
    logic [46:0] r_thp2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_en) r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side2 <= r_side1;
            r_thp2  <= r_m1 * ANG_K;
        end
    end

    // stage 3: round to Q30 theta
    logic [46:0] w_th_sum;
    t_side       w_side3;
    assign w_th_sum = r_thp2 + 47'd32768;
    always_comb begin
        w_side3    = r_side2;
        w_side3.th = w_th_sum[45:16];
    end

    logic  r_v3;
    t_side r_side3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_en) r_v3 <= r_v2;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_side3 <= w_side3;
    end

    // stage 4: theta squared
    logic        r_v4;
    t_side       r_side4;
    logic [59:0] r_t2p4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_en) r_v4 <= r_v3;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side4 <= r_side3;
            r_t2p4  <= r_side3.th * r_side3.th;
        end
    end

    t_side w_side4;
    always_comb begin
        w_side4    = r_side4;
        w_side4.t2 = r_t2p4[59:30];
    end

    // Horner steps: reciprocal multiply, then 1 - q and the next product
    logic [29:0] w_xs [HORNER_STEPS];
    logic [29:0] w_xc [HORNER_STEPS];
    t_side       w_qin [HORNER_STEPS];
    logic        w_vin [HORNER_STEPS];
    logic        r_qv [HORNER_STEPS];
    t_side       r_qside [HORNER_STEPS];
    logic [60:0] r_qs [HORNER_STEPS];
    logic [60:0] r_qc [HORNER_STEPS];
    logic        r_mv [HORNER_STEPS];
    t_side       r_mside [HORNER_STEPS];
    logic [60:0] r_ms [HORNER_STEPS];
    logic [60:0] r_mc [HORNER_STEPS];

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
        logic [30:0] w_ps;
        logic [30:0] w_pc;

        if (j == 0) begin : g_first
            assign w_qin[j] = w_side4;
            assign w_xs[j]  = r_t2p4[59:30];
            assign w_xc[j]  = r_t2p4[59:30];
            assign w_vin[j] = r_v4;
        end else begin : g_next
            assign w_qin[j] = r_mside[j-1];
            assign w_xs[j]  = r_ms[j-1][59:30];
            assign w_xc[j]  = r_mc[j-1][59:30];
            assign w_vin[j] = r_mv[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[j] <= 1'b0;
                r_mv[j] <= 1'b0;
            end else if (w_en) begin
                r_qv[j] <= w_vin[j];
                r_mv[j] <= r_qv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_qside[j] <= w_qin[j];
                r_qs[j]    <= w_xs[j] * SIN_R[j];
                r_qc[j]    <= w_xc[j] * COS_R[j];
            end
        end

        assign w_ps = Q30_ONE - 31'(r_qs[j] >> SIN_K[j]);
        assign w_pc = Q30_ONE - 31'(r_qc[j] >> COS_K[j]);

        if (j < HORNER_STEPS - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_mside[j] <= r_qside[j];
                    r_ms[j]    <= r_qside[j].t2 * w_ps;
                    r_mc[j]    <= r_qside[j].t2 * w_pc;
                end
            end
        end else begin : g_last
            // sine takes a final theta factor, cosine is done
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_mside[j] <= r_qside[j];
                    r_ms[j]    <= r_qside[j].th * w_ps;
                    r_mc[j]    <= 61'(w_pc);
                end
            end
        end
    end

    // round Q30 to Q14
    logic [30:0] w_s_sum;
    logic [30:0] w_c_sum;
    assign w_s_sum = {1'b0, r_ms[HORNER_STEPS-1][59:30]} + 31'd32768;
    assign w_c_sum = r_mc[HORNER_STEPS-1][30:0] + 31'd32768;

    logic        r_vf;
    t_side       r_sidef;
    logic [14:0] r_sf;
    logic [14:0] r_cf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vf <= 1'b0;
        else if (w_en) r_vf <= r_mv[HORNER_STEPS-1];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sidef <= r_mside[HORNER_STEPS-1];
            r_sf    <= w_s_sum[30:16];
            r_cf    <= w_c_sum[30:16];
        end
    end

    // quadrant symmetries
    logic signed [15:0] w_sv;
    logic signed [15:0] w_cv;
    logic signed [15:0] w_dx;
    logic signed [15:0] w_dy;
    assign w_sv = $signed({1'b0, r_sidef.swap ? r_cf : r_sf});
    assign w_cv = $signed({1'b0, r_sidef.swap ? r_sf : r_cf});

    always_comb begin
        case (t_quad'(r_sidef.quad))
            QUAD_I: begin
                w_dx = w_cv;
                w_dy = w_sv;
            end
            QUAD_II: begin
                w_dx = -w_sv;
                w_dy = w_cv;
            end
            QUAD_III: begin
                w_dx = -w_cv;
                w_dy = -w_sv;
            end
            default: begin
                w_dx = w_sv;
                w_dy = -w_cv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (w_en) o_valid <= r_vf;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) o_res <= '{ang: r_sidef.ang, dir_x: w_dx, dir_y: w_dy};
    end

endmodule

// ===== rtl/rds_recip.sv =====
// Pipelined restoring divider: delta distances round(2^30 / |dir|).
module rds_recip import rds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pipe_ctl  i_ctl,
    input  logic       i_valid,
    input  t_trig_res  i_res,
    output logic       o_valid,
    output t_recip_res o_res
);

    localparam int DIV_BITS     = 32;
    localparam int BITS_PER_STG = 2;
    localparam int DIV_STG      = DIV_BITS / BITS_PER_STG;

    typedef struct packed {
        logic [14:0] rem;
        logic [31:0] dq;   // dividend shifts out the top, quotient in the bottom
        logic [14:0] m;
        logic        zero;
    } t_lane;

    function automatic t_lane div_step(t_lane a);
        t_lane       b;
        logic [15:0] t;
        b = a;
        for (int k = 0; k < BITS_PER_STG; k++) begin
            t    = {b.rem, b.dq[31]};
            b.dq = {b.dq[30:0], 1'b0};
            if (t >= {1'b0, b.m}) begin
                b.rem   = 15'(t - {1'b0, b.m});
                b.dq[0] = 1'b1;
            end else begin
                b.rem = t[14:0];
            end
        end
        return b;
    endfunction

    function automatic t_lane lane_init(logic signed [15:0] d);
        t_lane       l;
        logic [15:0] mag;
        mag    = d[15] ? 16'(-d) : 16'(d);
        l.m    = mag[14:0];
        l.zero = (mag == 16'd0);
        l.rem  = '0;
        l.dq   = 32'(Q30_ONE) + 32'(mag[14:1]);
        return l;
    endfunction

    logic      r_v [DIV_STG+1];
    t_trig_res r_res [DIV_STG+1];
    t_lane     r_lx [DIV_STG+1];
    t_lane     r_ly [DIV_STG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_ctl.en) r_v[0] <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res[0] <= i_res;
            r_lx[0]  <= lane_init(i_res.dir_x);
            r_ly[0]  <= lane_init(i_res.dir_y);
        end
    end

    for (genvar s = 1; s <= DIV_STG; s++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s] <= 1'b0;
            else if (i_ctl.en) r_v[s] <= r_v[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_res[s] <= r_res[s-1];
                r_lx[s]  <= div_step(r_lx[s-1]);
                r_ly[s]  <= div_step(r_ly[s-1]);
            end
        end
    end

    assign o_valid       = r_v[DIV_STG];
    assign o_res.trig    = r_res[DIV_STG];
    assign o_res.delta_x = r_lx[DIV_STG].zero ? MAX32 : r_lx[DIV_STG].dq;
    assign o_res.delta_y = r_ly[DIV_STG].zero ? MAX32 : r_ly[DIV_STG].dq;

endmodule

// ===== rtl/rds_side.sv =====
// Player cell, step signs and side distances to the first grid lines.
module rds_side import rds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pipe_ctl   i_ctl,
    input  logic        i_valid,
    input  t_recip_res  i_res,
    input  logic [23:0] i_player_x,
    input  logic [23:0] i_player_y,
    output logic        o_valid,
    output t_ray_out    o_res
);

    localparam int PROD_W = NUM_W + 32;
    localparam logic [NUM_W-1:0]  SPAN_V = NUM_W'(1) << SPAN_LOG2;
    localparam logic [PROD_W:0]   HALF_V = (PROD_W + 1)'(1) << (SPAN_LOG2 - 1);

    function automatic logic [NUM_W-1:0] num_of(logic [23:0] pos, logic neg);
        logic [NUM_W-1:0] off;
        off = {1'b0, pos[SPAN_LOG2-1:0]};
        return neg ? off : SPAN_V - off;
    endfunction

    function automatic logic [31:0] side_of(logic [PROD_W-1:0] prod, logic inf,
                                            logic numz);
        logic [PROD_W:0] sum;
        logic [PROD_W:0] q;
        sum = {1'b0, prod} + HALF_V;
        q   = sum >> SPAN_LOG2;
        if (inf) return numz ? 32'd0 : MAX32;
        if (|q[PROD_W:32]) return MAX32;
        return q[31:0];
    endfunction

    logic [NUM_W-1:0] w_num_x;
    logic [NUM_W-1:0] w_num_y;
    assign w_num_x = num_of(i_player_x, i_res.trig.dir_x[15]);
    assign w_num_y = num_of(i_player_y, i_res.trig.dir_y[15]);

    // stage A: num * delta
    logic              r_av;
    t_recip_res        r_ares;
    logic [PROD_W-1:0] r_aprod_x;
    logic [PROD_W-1:0] r_aprod_y;
    logic              r_anumz_x;
    logic              r_anumz_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (i_ctl.en) r_av <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ares    <= i_res;
            r_aprod_x <= w_num_x * i_res.delta_x;
            r_aprod_y <= w_num_y * i_res.delta_y;
            r_anumz_x <= (w_num_x == '0);
            r_anumz_y <= (w_num_y == '0);
        end
    end

    // stage B: round, saturate, assemble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_ctl.en) o_valid <= r_av;
    end
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_res.ray_ang      <= r_ares.trig.ang;
            o_res.dir_x        <= r_ares.trig.dir_x;
            o_res.dir_y        <= r_ares.trig.dir_y;
            o_res.cell_x       <= 10'(i_player_x >> SPAN_LOG2);
            o_res.cell_y       <= 10'(i_player_y >> SPAN_LOG2);
            o_res.step_x       <= r_ares.trig.dir_x[15] ? 2'sb11 : 2'sb01;
            o_res.step_y       <= r_ares.trig.dir_y[15] ? 2'sb11 : 2'sb01;
            o_res.delta_dist_x <= r_ares.delta_x;
            o_res.delta_dist_y <= r_ares.delta_y;
            o_res.side_dist_x  <= side_of(r_aprod_x, r_ares.delta_x == MAX32, r_anumz_x);
            o_res.side_dist_y  <= side_of(r_aprod_y, r_ares.delta_y == MAX32, r_anumz_y);
        end
    end

endmodule

// ===== rtl/ray_dda_setup_core.sv =====
// Ray DDA setup: column index in, ray direction and DDA start values out.
//
// Input stream: one transaction per screen column, tdata holds the column index.
// Output stream: one transaction per input, in order, with the ray angle,
// Q1.14 direction, player cell, step signs, Q16.16 delta and side distances.
// APB port: base angle, angle increment, player_x, player_y at 0x0/0x4/0x8/0xC;
// write only while no column is in flight.
//
// From input transaction to output transaction a column passes 15 stages of
// angle and sine/cosine, 17 of the 2-bit-per-stage reciprocal divider, 2 of
// side distance and the output register.
// One column is taken every cycle while the skid register is empty.
//
// Reset clears the configuration registers and all valid bits, which empties
// the pipeline.
// When the receiver stalls, one result goes to a skid register and the whole
// pipeline then holds; tready on the input side drops until the skid drains.
module ray_dda_setup_core import rds_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [15:0]  i_s_axis_tdata,   // [9:0] column index
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // ray_ang, dir_x, dir_y, cell_x, cell_y, step_x, step_y,
    // delta_dist_x, delta_dist_y, side_dist_x, side_dist_y (low bit up)
    output logic [199:0] o_m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0] r_base_ang;
    logic [15:0] r_ang_incr;
    logic [23:0] r_player_x;
    logic [23:0] r_player_y;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ang <= '0;
            r_ang_incr <= '0;
            r_player_x <= '0;
            r_player_y <= '0;
        end else if (w_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_BASE_ANG: r_base_ang <= pwdata[15:0];
                REG_ANG_INCR: r_ang_incr <= pwdata[15:0];
                REG_PLAYER_X: r_player_x <= pwdata[23:0];
                REG_PLAYER_Y: r_player_y <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_BASE_ANG: prdata = {16'd0, r_base_ang};
            REG_ANG_INCR: prdata = {16'd0, r_ang_incr};
            REG_PLAYER_X: prdata = {8'd0, r_player_x};
            REG_PLAYER_Y: prdata = {8'd0, r_player_y};
            default:      prdata = '0;
        endcase
    end

    // pipeline
    logic       r_skid_valid;
    t_pipe_ctl  w_ctl;
    logic       w_tv;
    t_trig_res  w_tres;
    logic       w_rv;
    t_recip_res w_rres;
    logic       w_pv;
    t_ray_out   w_pres;

    assign w_ctl.en        = !r_skid_valid;
    assign o_s_axis_tready = !r_skid_valid;

    rds_trig u_trig (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_valid    (i_s_axis_tvalid),
        .i_col_idx  (i_s_axis_tdata[9:0]),
        .i_base_ang (r_base_ang),
        .i_ang_incr (r_ang_incr),
        .o_valid    (w_tv),
        .o_res      (w_tres)
    );

    rds_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_valid (w_tv),
        .i_res   (w_tres),
        .o_valid (w_rv),
        .o_res   (w_rres)
    );

    rds_side u_side (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_valid    (w_rv),
        .i_res      (w_rres),
        .i_player_x (r_player_x),
        .i_player_y (r_player_y),
        .o_valid    (w_pv),
        .o_res      (w_pres)
    );

    // output register plus skid
    logic     r_out_valid;
    t_ray_out r_out;
    t_ray_out r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_pv) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out       <= w_pres;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_pres;
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.side_dist_y, r_out.side_dist_x,
                              r_out.delta_dist_y, r_out.delta_dist_x,
                              r_out.step_y, r_out.step_x,
                              r_out.cell_y, r_out.cell_x,
                              r_out.dir_y, r_out.dir_x, r_out.ray_ang};

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output register is empty");

    a_stall_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pv && !r_skid_valid && r_out_valid && !i_m_axis_tready) |=> r_skid_valid)
        else $error("result arriving under stall was not captured");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.dir_x <= 16'sd16384) && (r_out.dir_x >= -16'sd16384)
                     && (r_out.dir_y <= 16'sd16384) && (r_out.dir_y >= -16'sd16384))
        else $error("direction outside Q1.14 unit range");

    a_step_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.step_x[1] == r_out.dir_x[15])
                     && (r_out.step_y[1] == r_out.dir_y[15]))
        else $error("step sign disagrees with direction");

endmodule

// ===== sim/tb_ray_dda_setup_core.sv =====
// Self-checking testbench for the ray DDA setup core: directed table, then random columns.
module tb_ray_dda_setup_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rds_pkg::*;

    localparam int N_RANDOM = 630;
    localparam int N_ROWS   = 14;
    localparam logic [3:0] REG_START = {REG_BASE_ANG, 2'b00};
    localparam logic [3:0] REG_STEP  = {REG_ANG_INCR, 2'b00};
    localparam logic [3:0] REG_PX    = {REG_PLAYER_X, 2'b00};
    localparam logic [3:0] REG_PY    = {REG_PLAYER_Y, 2'b00};
    localparam logic [3:0] REG_ODD   = {REG_BASE_ANG, 2'b11};   // low address bits not decoded
    localparam int PIPE_LAT = 35;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [15:0]  i_s_axis_tdata;   // [9:0] column index
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [199:0] o_m_axis_tdata;   // ray_ang .. side_dist_y, low bit up
    logic         psel, penable, pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    ray_dda_setup_core u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("ray_dda_setup_core regression: fail");
        $finish;
    end

    // shadow copy of the configuration registers
    logic [15:0] cfg_start, cfg_step;
    logic [23:0] cfg_px, cfg_py;

    t_ray_out ray_q[$];
    int       n_err;
    bit       rx_on;

    function automatic void eighth_trig(input logic [63:0] m,
                                        output int s, output int c);
        logic [63:0] th, t2, p, a;
        th = (m * 64'd6746518852 + 64'd32768) >> 16;
        t2 = (th * th) >> 30;
        a = 64'd1 << 30;
        p = a - t2 / 72;
        p = a - ((t2 * p) >> 30) / 42;
        p = a - ((t2 * p) >> 30) / 20;
        p = a - ((t2 * p) >> 30) / 6;
        s = int'((((th * p) >> 30) + 64'd32768) >> 16);
        p = a - t2 / 56;
        p = a - ((t2 * p) >> 30) / 30;
        p = a - ((t2 * p) >> 30) / 12;
        p = a - ((t2 * p) >> 30) / 2;
        c = int'((p + 64'd32768) >> 16);
    endfunction

    function automatic logic [31:0] recip_q16(input int d);
        logic [63:0] m;
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (m == 0) return 32'hFFFF_FFFF;
        return 32'(((64'd1 << 30) + m / 2) / m);
    endfunction

    function automatic void axis_start(input logic [23:0] pos, input int d,
                                       input logic [31:0] dd,
                                       output logic [9:0] cell_no, output logic [31:0] side);
        logic [63:0] span, off, num, s;
        span = 64'(TILE_SIZE) * 256;
        off  = 64'(pos) % span;
        num  = (d < 0) ? off : span - off;
        cell_no = 10'((64'(pos) >> 8) / TILE_SIZE);
        if (dd == 32'hFFFF_FFFF) s = (num == 0) ? 64'd0 : 64'hFFFF_FFFF;
        else s = (num * 64'(dd) + span / 2) / span;
        side = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(s);
    endfunction

    function automatic t_ray_out predict_ray(input logic [9:0] idx);
        t_ray_out r;
        logic [15:0] ang;
        int s, c, cs, sn;
        logic [13:0] rem;
        ang = cfg_start + 16'(idx * cfg_step);
        rem = ang[13:0];
        if (rem <= 14'd8192) eighth_trig(64'(rem), s, c);
        else eighth_trig(64'(16384 - rem), c, s);
        case (ang[15:14])
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
        r.ray_ang      = ang;
        r.dir_x        = 16'(cs);
        r.dir_y        = 16'(sn);
        r.step_x       = (cs < 0) ? -2'sd1 : 2'sd1;
        r.step_y       = (sn < 0) ? -2'sd1 : 2'sd1;
        r.delta_dist_x = recip_q16(cs);
        r.delta_dist_y = recip_q16(sn);
        axis_start(cfg_px, cs, r.delta_dist_x, r.cell_x, r.side_dist_x);
        axis_start(cfg_py, sn, r.delta_dist_y, r.cell_y, r.side_dist_y);
        return r;
    endfunction

    // tdata packs the first field lowest; t_ray_out packs it highest
    function automatic logic [199:0] pack_ray(input t_ray_out r);
        return {r.side_dist_y, r.side_dist_x, r.delta_dist_y, r.delta_dist_x,
                r.step_y, r.step_x, r.cell_y, r.cell_x, r.dir_y, r.dir_x, r.ray_ang};
    endfunction

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (t_reg_idx'(addr[3:2]))
            REG_BASE_ANG: cfg_start = data[15:0];
            REG_ANG_INCR: cfg_step  = data[15:0];
            REG_PLAYER_X: cfg_px    = data[23:0];
            REG_PLAYER_Y: cfg_py    = data[23:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [15:0] sa, input logic [15:0] st,
                           input logic [23:0] px, input logic [23:0] py);
        apb_write(REG_START, {16'hFFFF, sa});
        apb_write(REG_STEP, {16'hFFFF, st});
        apb_write(REG_PX, {8'hFF, px});
        apb_write(REG_PY, {8'hFF, py});
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (ray_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    // tvalid stays high into the next call when it follows with no gap
    task automatic send_column(input logic [9:0] idx);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 1);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'($urandom_range(0, 63)), idx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ray_q.push_back(predict_ray(idx));
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!rx_on) i_m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 19) == 0) i_m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 2) == 0) i_m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 30) == 0) i_m_axis_tready <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (ray_q.size() == 0) begin
                $display("%t unexpected result %h", $realtime, o_m_axis_tdata);
                n_err++;
            end else begin
                t_ray_out exp_r;
                exp_r = ray_q.pop_front();
                if (o_m_axis_tdata !== pack_ray(exp_r)) begin
                    $display("%t mismatch expected %h actual %h", $realtime,
                             pack_ray(exp_r), o_m_axis_tdata);
                    n_err++;
                end
            end
        end
    end

    typedef struct {
        logic [15:0] sa, st;
        logic [23:0] px, py;
        logic [9:0]  idx;
        bit          known;
        logic [15:0] ang;
        logic [31:0] ddx, ddy;
    } t_dir_row;

    t_dir_row dir_rows [N_ROWS] = '{
        // after reset: angle 0, cos one, sin zero -> delta_y saturated
        '{16'h0000, 16'h0000, 24'h0, 24'h0, 10'd0, 1'b1, 16'h0000, 32'h0001_0000,
          32'hFFFF_FFFF},
        '{16'h0000, 16'h0000, 24'h0, 24'h0, 10'd1023, 1'b1, 16'h0000, 32'h0001_0000,
          32'hFFFF_FFFF},
        // quarter turn: cos zero
        '{16'h4000, 16'h0000, 24'h0, 24'h0, 10'd5, 1'b1, 16'h4000, 32'hFFFF_FFFF,
          32'h0001_0000},
        '{16'h8000, 16'h0000, 24'h004000, 24'h0, 10'd0, 1'b1, 16'h8000, 32'h0001_0000,
          32'hFFFF_FFFF},
        '{16'hC000, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 10'd0, 1'b1, 16'hC000, 32'hFFFF_FFFF,
          32'h0001_0000},
        // angle wraps past a full turn
        '{16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 10'd1023, 1'b0, '0, '0, '0},
        '{16'hFFFF, 16'h0001, 24'h003FFF, 24'h004001, 10'd1, 1'b0, '0, '0, '0},
        '{16'h2000, 16'h0000, 24'h123456, 24'hABCDEF, 10'd0, 1'b0, '0, '0, '0},
        '{16'h1FFF, 16'h0002, 24'h000001, 24'hFFC000, 10'd1, 1'b0, '0, '0, '0},
        '{16'h0001, 16'h0040, 24'h40_0000, 24'h0, 10'd512, 1'b0, '0, '0, '0},
        '{16'h3FFF, 16'h0001, 24'h0, 24'h004000, 10'd2, 1'b0, '0, '0, '0},
        '{16'h5555, 16'h0101, 24'hAAAAAA, 24'h555555, 10'd341, 1'b0, '0, '0, '0},
        '{16'hAAAA, 16'h8000, 24'h000080, 24'hFFFF80, 10'd682, 1'b0, '0, '0, '0},
        '{16'h0000, 16'h0040, 24'h0, 24'h0, 10'd256, 1'b1, 16'h4000, 32'hFFFF_FFFF,
          32'h0001_0000}
    };

    initial begin
        t_ray_out pr;
        int k;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_start = '0; cfg_step = '0; cfg_px = '0; cfg_py = '0;
        n_err = 0;
        rx_on = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_on = 1'b1;

        foreach (dir_rows[r]) begin
            if (r != 0) begin
                drain();
                set_cfg(dir_rows[r].sa, dir_rows[r].st, dir_rows[r].px, dir_rows[r].py);
            end
            pr = predict_ray(dir_rows[r].idx);
            if (dir_rows[r].known && (pr.ray_ang !== dir_rows[r].ang ||
                pr.delta_dist_x !== dir_rows[r].ddx || pr.delta_dist_y !== dir_rows[r].ddy)) begin
                $display("%t table row %0d expected %h %h %h actual %h %h %h", $realtime, r,
                         dir_rows[r].ang, dir_rows[r].ddx, dir_rows[r].ddy,
                         pr.ray_ang, pr.delta_dist_x, pr.delta_dist_y);
                n_err++;
            end
            send_column(dir_rows[r].idx);
        end
        drain();
        apb_write(REG_ODD, 32'hDEAD_BEEF);
        send_column(10'd7);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 90 == 0) begin
                drain();
                if ($urandom_range(0, 3) == 0)
                    set_cfg(16'($urandom), 16'($urandom_range(0, 3) * 16'h1000),
                            24'($urandom_range(0, 63) * 16384), 24'($urandom));
                else
                    set_cfg(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
            end
            if (k == 300) drain();   // let the pipe empty once mid-run
            send_column(10'($urandom));
        end

        fork
            drain();
            begin
                repeat (200000) @(posedge i_clk);
                n_err++;
            end
        join_any
        if (n_err == 0)
            $display("ray_dda_setup_core regression: pass");
        else
            $display("ray_dda_setup_core regression: fail");
        $finish;
    end
endmodule
